// ----- rtl/core/vn_pkg.sv -----
`default_nettype none
package vn_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SQ_W          = 64;
    localparam int DIV_W         = 62;
    localparam int UNIT_SHIFT    = 30;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } vn_in_t;

    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic [31:0]        length;
        logic               zero_vector;
    } vn_out_t;
endpackage
`default_nettype wire

// ----- rtl/core/vn_sqrt.sv -----
`default_nettype none
// Pipelined restoring square root, one result bit per stage.
module vn_sqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic [vn_pkg::SQ_W-1:0]   radicand,
    output logic      [31:0]               root
);
    import vn_pkg::*;
    localparam int NS = 32;

    logic [SQ_W-1:0] rem_reg  [NS+1];
    logic [SQ_W-1:0] rad_reg  [NS+1];
    logic [31:0]     root_reg [NS+1];

    always_comb
    begin
        rem_reg[0]  = '0;
        rad_reg[0]  = radicand;
        root_reg[0] = '0;
    end

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [SQ_W-1:0] rem_next;
        logic [SQ_W-1:0] trial;
        logic [SQ_W-1:0] rem_sh;
        always_comb
        begin
            rem_sh = {rem_reg[s][SQ_W-3:0], rad_reg[s][SQ_W-1 -: 2]};
            trial  = {{(SQ_W-34){1'b0}}, root_reg[s], 2'b01};
            rem_next = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                rem_reg[s+1]  <= '0;
                rad_reg[s+1]  <= '0;
                root_reg[s+1] <= '0;
            end else if (en) begin
                rem_reg[s+1]  <= rem_next;
                rad_reg[s+1]  <= {rad_reg[s][SQ_W-3:0], 2'b00};
                root_reg[s+1] <= {root_reg[s][30:0], rem_sh >= trial};
            end
        end
    end

    assign root = root_reg[NS];
endmodule
`default_nettype wire

// ----- rtl/core/vn_div_lane.sv -----
`default_nettype none
// One lane: pipelined restoring divide of |c|<<30 by the length, sign fixup.
module vn_div_lane (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic [31:0]        mag,
    input  wire logic               neg,
    input  wire logic [31:0]        divisor,
    output logic signed [31:0]      quot
);
    import vn_pkg::*;
    localparam int NS = DIV_W;

    logic [32:0]      rem_reg [NS+1];
    logic [DIV_W-1:0] num_reg [NS+1];
    logic [31:0]      dv_reg  [NS+1];
    logic             neg_reg [NS+1];

    always_comb
    begin
        rem_reg[0] = '0;
        num_reg[0] = {mag, {UNIT_SHIFT{1'b0}}};
        dv_reg[0]  = divisor;
        neg_reg[0] = neg;
    end

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [32:0] sh;
        logic        ge;
        always_comb
        begin
            sh = {rem_reg[s][31:0], num_reg[s][DIV_W-1]};
            ge = sh >= {1'b0, dv_reg[s]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                rem_reg[s+1] <= '0;
                num_reg[s+1] <= '0;
                dv_reg[s+1]  <= '0;
                neg_reg[s+1] <= 1'b0;
            end else if (en) begin
                rem_reg[s+1] <= ge ? sh - {1'b0, dv_reg[s]} : sh;
                num_reg[s+1] <= {num_reg[s][DIV_W-2:0], ge};
                dv_reg[s+1]  <= dv_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    assign quot = neg_reg[NS] ? -$signed(num_reg[NS][31:0]) : $signed(num_reg[NS][31:0]);
endmodule
`default_nettype wire

// ----- rtl/core/vector3_normalize.sv -----
`default_nettype none
// Pipeline: magnitude stage, sum-of-squares stage, square-root stages, then divide stages.
// Throughput: one beat per cycle; the whole pipeline advances whenever the
// output register is free, so a stall freezes every stage.
// Reset: asynchronous active low, clears all stage valids and registers.
module vector3_normalize #(
    parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire vn_pkg::vn_in_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output vn_pkg::vn_out_t      out_data
);
    import vn_pkg::*;
    // FRAC_BITS cancels in the math; it only names the fixed-point format.
    localparam int LAT = 2 + 32 + DIV_W;
    localparam int FB  = FRAC_BITS;

    logic              en;
    logic [LAT-1:0]    vld_reg;
    logic [31:0]       ax_reg, ay_reg, az_reg;   // magnitudes, 2^31 fits unsigned
    logic [2:0]        ng_reg;
    logic [SQ_W-1:0]   sum_reg;
    logic [31:0]       root;

    // advance when the tail is empty or leaves this cycle
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;
    assign out_valid = vld_reg[LAT-1] && (FB >= 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // stage 1: magnitudes and signs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ax_reg <= '0; ay_reg <= '0; az_reg <= '0; ng_reg <= '0;
        end else if (en) begin
            ax_reg <= in_data.vec_x[31] ? 32'(-in_data.vec_x) : in_data.vec_x;
            ay_reg <= in_data.vec_y[31] ? 32'(-in_data.vec_y) : in_data.vec_y;
            az_reg <= in_data.vec_z[31] ? 32'(-in_data.vec_z) : in_data.vec_z;
            ng_reg <= {in_data.vec_x[31], in_data.vec_y[31], in_data.vec_z[31]};
        end
    end

    // stage 2: sum of squares (three 32x32 lanes, merged by an adder)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (en)
            sum_reg <= SQ_W'({32'b0, ax_reg} * {32'b0, ax_reg})
                     + SQ_W'({32'b0, ay_reg} * {32'b0, ay_reg})
                     + SQ_W'({32'b0, az_reg} * {32'b0, az_reg});
    end

    // magnitudes ride alongside the root pipeline
    logic [31:0] mx_reg [33], my_reg [33], mz_reg [33];
    logic [2:0]  nd_reg [33];
    always_comb
    begin
        mx_reg[0] = ax_reg; my_reg[0] = ay_reg; mz_reg[0] = az_reg; nd_reg[0] = ng_reg;
    end
    for (genvar d = 0; d < 32; d++) begin : g_dly
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                mx_reg[d+1] <= '0; my_reg[d+1] <= '0; mz_reg[d+1] <= '0; nd_reg[d+1] <= '0;
            end else if (en) begin
                mx_reg[d+1] <= mx_reg[d]; my_reg[d+1] <= my_reg[d];
                mz_reg[d+1] <= mz_reg[d]; nd_reg[d+1] <= nd_reg[d];
            end
        end
    end

    vn_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .radicand(sum_reg), .root(root)
    );

    // root is valid alongside mag after the delay chain and the mxd registers (sum stage plus root stages)
    logic [31:0] mxd_reg, myd_reg, mzd_reg;
    logic [2:0]  ndd_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mxd_reg <= '0; myd_reg <= '0; mzd_reg <= '0; ndd_reg <= '0;
        end else if (en) begin
            mxd_reg <= mx_reg[32]; myd_reg <= my_reg[32];
            mzd_reg <= mz_reg[32]; ndd_reg <= nd_reg[32];
        end
    end

    logic signed [31:0] qx, qy, qz;
    vn_div_lane u_lx (.clk(clk), .rst_n(rst_n), .en(en), .mag(mxd_reg),
        .neg(ndd_reg[2]), .divisor(root), .quot(qx));
    vn_div_lane u_ly (.clk(clk), .rst_n(rst_n), .en(en), .mag(myd_reg),
        .neg(ndd_reg[1]), .divisor(root), .quot(qy));
    vn_div_lane u_lz (.clk(clk), .rst_n(rst_n), .en(en), .mag(mzd_reg),
        .neg(ndd_reg[0]), .divisor(root), .quot(qz));

    // length rides beside the divide lanes
    logic [31:0] len_reg [DIV_W+1];
    assign len_reg[0] = root;
    for (genvar d = 0; d < DIV_W; d++) begin : g_len
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                len_reg[d+1] <= '0;
            else if (en)
                len_reg[d+1] <= len_reg[d];
        end
    end

    // merge: a zero length forces zero units and raises the flag
    always_comb
    begin
        out_data.length      = len_reg[DIV_W];
        out_data.zero_vector = (len_reg[DIV_W] == '0);
        out_data.unit_x      = out_data.zero_vector ? '0 : qx;
        out_data.unit_y      = out_data.zero_vector ? '0 : qy;
        out_data.unit_z      = out_data.zero_vector ? '0 : qz;
    end
endmodule
`default_nettype wire

// ----- rtl/core/vn_checker.sv -----
`default_nettype none
module vn_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_stall,
    input wire logic            out_valid,
    input wire logic            out_stall,
    input wire vn_pkg::vn_out_t out_data
);
    a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_vector |-> out_data.unit_x == 0
            && out_data.unit_y == 0 && out_data.unit_z == 0 && out_data.length == 0)
        else $error("zero vector with nonzero outputs");
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.length == 0 |-> out_data.zero_vector)
        else $error("zero length without flag");
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output changed");
endmodule

bind vector3_normalize vn_checker u_vn_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ----- verif/vector3_normalize_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vector3_normalize_tb;
    import vn_pkg::*;

    // Pipeline depth of the block; used for the drain waits.
    localparam int PIPE_LAT   = 96;
    localparam int N_RANDOM   = 1950;
    localparam longint CYCLE_LIMIT = 400000;

    // Idle schemes for the two sides, stepped through in order.
    typedef enum int {
        IDLE_SEND_LIGHT,
        IDLE_RECV_LIGHT,
        IDLE_NONE
    } idle_mode_t;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    vn_in_t  in_data;
    logic    out_valid;
    logic    out_stall;
    vn_out_t out_data;

    vector3_normalize dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    vn_in_t     pending_vecs[$];
    vn_out_t    expected_units[$];
    idle_mode_t idle_mode;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         hold_send;       // sender paused for a pipeline-depth wait after a drain
    int         mismatch_cnt = 0;
    int         beats_in = 0;
    int         beats_out = 0;
    int         zero_cnt = 0;
    longint     cycle_cnt = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Floor square root, bit-by-bit restoring method on a 66-bit sum.
    function automatic logic [32:0] floor_sqrt(input logic [65:0] v);
        logic [65:0] rem;
        logic [65:0] root;
        logic [65:0] bitv;
        rem  = v;
        root = '0;
        bitv = 66'd1 << 64;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root[32:0];
    endfunction

    // Component over length in Q2.30, truncated toward zero.
    function automatic logic [31:0] scale_component(input logic signed [31:0] c,
                                                    input logic [32:0] len);
        logic [32:0] mag;
        logic [63:0] quo;
        mag = c[31] ? (33'd0 - {1'b1, c}) : {1'b0, c};
        quo = ({31'd0, mag} << 30) / {31'd0, len};
        if (c[31])
            quo = 64'd0 - quo;
        return quo[31:0];
    endfunction

    function automatic vn_out_t normalize_vec(input vn_in_t v);
        vn_out_t     r;
        logic [32:0] mx;
        logic [32:0] my;
        logic [32:0] mz;
        logic [65:0] sumsq;
        logic [32:0] len;
        mx = v.vec_x[31] ? (33'd0 - {1'b1, v.vec_x}) : {1'b0, v.vec_x};
        my = v.vec_y[31] ? (33'd0 - {1'b1, v.vec_y}) : {1'b0, v.vec_y};
        mz = v.vec_z[31] ? (33'd0 - {1'b1, v.vec_z}) : {1'b0, v.vec_z};
        sumsq = {33'd0, mx} * {33'd0, mx} + {33'd0, my} * {33'd0, my}
              + {33'd0, mz} * {33'd0, mz};
        len = floor_sqrt(sumsq);
        r = '0;
        if (len == 0)
        begin
            r.zero_vector = 1'b1;
            return r;
        end
        r.unit_x = scale_component(v.vec_x, len);
        r.unit_y = scale_component(v.vec_y, len);
        r.unit_z = scale_component(v.vec_z, len);
        r.length = len[31:0];
        return r;
    endfunction

    function automatic vn_in_t make_vec(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z);
        vn_in_t v;
        v.vec_x = x;
        v.vec_y = y;
        v.vec_z = z;
        return v;
    endfunction

    // Random component: half full range, the rest small, extreme, zero or 16-bit values
    // so that short vectors and near-axis directions are common.
    function automatic logic [31:0] rand_component();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom;
        else if (sel < 7)
            return $urandom_range(0, 8) - 4;
        else if (sel < 8)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        else if (sel < 9)
            return 32'd0;
        else
            return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
    endfunction

    // Driver: presents the next pending vector; a stalled beat is held steady.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (!in_valid || !in_stall)
            begin
                if (in_valid)
                begin
                    // Beat just accepted: model its result now.
                    expected_units.push_back(normalize_vec(in_data));
                    beats_in++;
                end
                if (pending_vecs.size() > 0 && !hold_send &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_vecs.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks accepted results in order; also drives random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        vn_out_t exp_r;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            cycle_cnt++;
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (expected_units.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result beat: %p", out_data);
                end
                else
                begin
                    exp_r = expected_units.pop_front();
                    if (exp_r.zero_vector)
                        zero_cnt++;
                    if (out_data.unit_x !== exp_r.unit_x ||
                        out_data.unit_y !== exp_r.unit_y ||
                        out_data.unit_z !== exp_r.unit_z ||
                        out_data.length !== exp_r.length ||
                        out_data.zero_vector !== exp_r.zero_vector)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("result mismatch: expected %p got %p",
                                     exp_r, out_data);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("vector3_normalize_tb failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_vecs.size() > 0 || in_valid || expected_units.size() > 0)
            @(posedge clk);
    endtask

    task automatic set_idle(input idle_mode_t m);
        idle_mode = m;
        case (m)
            IDLE_SEND_LIGHT:
            begin
                send_idle_pct = 16;
                recv_idle_pct = 69;
            end
            IDLE_RECV_LIGHT:
            begin
                send_idle_pct = 69;
                recv_idle_pct = 16;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    initial
    begin
        int i;
        rst_n         = 1'b0;
        hold_send     = 1'b0;
        set_idle(IDLE_SEND_LIGHT);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero vector, axis extremes, most negative at full
        // magnitude, largest length, tiny vectors, sign mixes.
        pending_vecs.push_back(make_vec(0, 0, 0));
        pending_vecs.push_back(make_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_vecs.push_back(make_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_vecs.push_back(make_vec(32'h8000_0000, 0, 0));
        pending_vecs.push_back(make_vec(0, 32'h7fff_ffff, 0));
        pending_vecs.push_back(make_vec(0, 0, 32'h8000_0000));
        pending_vecs.push_back(make_vec(1, 0, 0));
        pending_vecs.push_back(make_vec(0, 32'hffff_ffff, 0));
        pending_vecs.push_back(make_vec(0, 0, 1));
        pending_vecs.push_back(make_vec(1, 1, 1));
        pending_vecs.push_back(make_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        pending_vecs.push_back(make_vec(32'h0001_0000, 32'h0001_0000, 0));
        pending_vecs.push_back(make_vec(32'h0003_0000, 32'h0004_0000, 0));
        pending_vecs.push_back(make_vec(32'hfffd_0000, 0, 32'h0004_0000));
        pending_vecs.push_back(make_vec(32'h7fff_ffff, 32'h8000_0000, 1));
        pending_vecs.push_back(make_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f));
        pending_vecs.push_back(make_vec(2, 3, 32'hffff_fffa));
        pending_vecs.push_back(make_vec(0, 0, 0));

        // Random part across three idle schemes.
        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
            begin
                wait_drained();
                // With every result back, the sender holds off for the pipeline depth.
                hold_send = 1'b1;
                repeat (PIPE_LAT) @(posedge clk);
                hold_send = 1'b0;
                set_idle(IDLE_RECV_LIGHT);
            end
            else if (i == 2 * N_RANDOM / 3)
            begin
                wait_drained();
                set_idle(IDLE_NONE);
            end
            pending_vecs.push_back(make_vec(rand_component(), rand_component(),
                                            rand_component()));
        end

        wait_drained();
        repeat (PIPE_LAT + 10) @(posedge clk);

        $display("covered %0d vectors in, %0d results out, %0d zero vectors",
                 beats_in, beats_out, zero_cnt);
        $display("idle schemes: sender-light, receiver-light, none; %0d mismatches",
                 mismatch_cnt);
        if (mismatch_cnt == 0 && expected_units.size() == 0)
            $display("vector3_normalize_tb passed");
        else
            $display("vector3_normalize_tb failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/vn_pkg.sv
rtl/core/vn_sqrt.sv
rtl/core/vn_div_lane.sv
rtl/core/vector3_normalize.sv
rtl/core/vn_checker.sv
verif/vector3_normalize_tb.sv
